/* rtl/core/jcs_pkg.sv */
// Shared types, character codes and scan modes for the Java comment stripper.
// Depends on nothing; every other file of the block imports it.
package jcs_pkg;

   localparam int UNIT_BITS = 16;

   localparam logic [UNIT_BITS-1:0] CH_SLASH  = UNIT_BITS'('h2F);
   localparam logic [UNIT_BITS-1:0] CH_STAR   = UNIT_BITS'('h2A);
   localparam logic [UNIT_BITS-1:0] CH_DQUOTE = UNIT_BITS'('h22);
   localparam logic [UNIT_BITS-1:0] CH_SQUOTE = UNIT_BITS'('h27);
   localparam logic [UNIT_BITS-1:0] CH_BSLASH = UNIT_BITS'('h5C);
   localparam logic [UNIT_BITS-1:0] CH_NL     = UNIT_BITS'('h0A);

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_LINE   = 3'd1;
   localparam logic [2:0] MODE_BLOCK  = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_CHAR   = 3'd4;
   localparam logic [2:0] MODE_TEXT   = 3'd5;

   localparam int JOB_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [UNIT_BITS-1:0] code_unit;
      logic                 last_unit;
   } req_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0] out_unit;
      logic                 out_valid;
      logic                 out_last;
   } rsp_type;

   // Delimiter matches for one unit and its two lookahead units.
   typedef struct packed {
      logic c_slash;
      logic c_star;
      logic c_dquote;
      logic c_squote;
      logic c_bslash;
      logic c_nl;
      logic n1_slash;
      logic n1_star;
      logic n1_dquote;
      logic n2_dquote;
   } flags_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0] unit;
      flags_type            flags;
      logic                 final_step;
      logic                 end_text;
   } job_type;

   function automatic flags_type classify(input logic [UNIT_BITS-1:0] c,
                                          input logic [UNIT_BITS-1:0] n1,
                                          input logic [UNIT_BITS-1:0] n2);
      flags_type f;
      f.c_slash   = (c == CH_SLASH);
      f.c_star    = (c == CH_STAR);
      f.c_dquote  = (c == CH_DQUOTE);
      f.c_squote  = (c == CH_SQUOTE);
      f.c_bslash  = (c == CH_BSLASH);
      f.c_nl      = (c == CH_NL);
      f.n1_slash  = (n1 == CH_SLASH);
      f.n1_star   = (n1 == CH_STAR);
      f.n1_dquote = (n1 == CH_DQUOTE);
      f.n2_dquote = (n2 == CH_DQUOTE);
      return f;
   endfunction

endpackage

/* rtl/core/jcs_front.sv */
// Front end: lookahead window, end-of-text flush and delimiter classification.
// Depends on jcs_pkg; feeds decide jobs into jcs_job_fifo.
module jcs_front
   import jcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    job_push,
   output job_type job_word,
   input  logic    job_full
);

   logic [UNIT_BITS-1:0] w0_ff, w0_in;
   logic [UNIT_BITS-1:0] w1_ff, w1_in;
   logic [UNIT_BITS-1:0] w2_ff, w2_in;
   logic [1:0]           fill_ff, fill_in;
   logic [1:0]           flush_cnt_ff, flush_cnt_in;
   logic                 flushing_ff, flushing_in;
   logic                 accept;
   logic [UNIT_BITS-1:0] n1_masked;
   logic [UNIT_BITS-1:0] n2_masked;

   assign req_full = flushing_ff || job_full;
   assign accept   = req_push && !req_full;

   // Missing lookahead reads as zero during the flush.
   assign n1_masked = (flush_cnt_ff >= 2'd2) ? w1_ff : '0;
   assign n2_masked = (flush_cnt_ff == 2'd3) ? w2_ff : '0;

   always_comb begin
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      fill_in      = fill_ff;
      flush_cnt_in = flush_cnt_ff;
      flushing_in  = flushing_ff;
      job_push     = 1'b0;
      job_word     = '0;
      if (flushing_ff) begin
         job_word.unit       = w0_ff;
         job_word.flags      = classify(w0_ff, n1_masked, n2_masked);
         job_word.final_step = 1'b1;
         job_word.end_text   = (flush_cnt_ff == 2'd1);
         if (!job_full) begin
            job_push     = 1'b1;
            w0_in        = w1_ff;
            w1_in        = w2_ff;
            flush_cnt_in = flush_cnt_ff - 2'd1;
            if (flush_cnt_ff == 2'd1) begin
               flushing_in = 1'b0;
            end
         end
      end else if (accept) begin
         if (req_data.last_unit) begin
            case (fill_ff)
               2'd0: w0_in = req_data.code_unit;
               2'd1: w1_in = req_data.code_unit;
               default: w2_in = req_data.code_unit;
            endcase
            flush_cnt_in = fill_ff + 2'd1;
            flushing_in  = 1'b1;
            fill_in      = 2'd0;
         end else if (fill_ff == 2'd2) begin
            job_push            = 1'b1;
            job_word.unit       = w0_ff;
            job_word.flags      = classify(w0_ff, w1_ff, req_data.code_unit);
            job_word.final_step = 1'b0;
            job_word.end_text   = 1'b0;
            w0_in               = w1_ff;
            w1_in               = req_data.code_unit;
         end else if (fill_ff == 2'd1) begin
            w1_in   = req_data.code_unit;
            fill_in = 2'd2;
         end else begin
            w0_in   = req_data.code_unit;
            fill_in = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w0_ff <= w0_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      if (reset) begin
         fill_ff      <= 2'd0;
         flush_cnt_ff <= 2'd0;
         flushing_ff  <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         flush_cnt_ff <= flush_cnt_in;
         flushing_ff  <= flushing_in;
      end
   end

endmodule

/* rtl/core/jcs_job_fifo.sv */
// Short queue of decide jobs between front and back end.
// Depends on jcs_pkg for job_type and JOB_DEPTH.
module jcs_job_fifo
   import jcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_word,
   output logic    full,
   input  logic    pop,
   output job_type pop_word,
   output logic    empty
);

   localparam int PTR_BITS = $clog2(JOB_DEPTH);

   job_type               mem_ff [JOB_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]     count_ff;
   logic                  do_push, do_pop;

   assign full     = (count_ff == (PTR_BITS+1)'(JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
      end
   end

endmodule

/* rtl/core/jcs_back.sv */
// Back end: scan-mode sequencer that decides each job and emits kept units,
// plus the result queue. Depends on jcs_pkg.
module jcs_back
   import jcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_word,
   output logic    job_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int PTR_BITS = $clog2(RSP_DEPTH);

   // Scan state
   logic [2:0]           mode_ff, mode_in;
   logic [1:0]           skip_ff, skip_in;
   logic                 esc_ff, esc_in;
   // Emit sequencer
   logic [1:0]           rem_ff, rem_in;
   logic [UNIT_BITS-1:0] cur_unit_ff, cur_unit_in;
   logic                 cur_final_ff, cur_final_in;
   logic                 end_pend_ff, end_pend_in;
   logic [UNIT_BITS-1:0] held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;
   // Decide outcome for the job at the queue head
   logic [2:0]           d_mode;
   logic [1:0]           d_skip;
   logic                 d_esc;
   logic [1:0]           d_emits;
   flags_type            f;
   // Result queue
   rsp_type              oq_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]  oq_wr_ff, oq_rd_ff;
   logic [PTR_BITS:0]    oq_cnt_ff;
   logic                 oq_full, oq_push, oq_pop;
   rsp_type              oq_word;
   logic                 emit;
   logic [UNIT_BITS-1:0] emit_unit;
   logic                 emit_final;

   assign f = job_word.flags;

   always_comb begin
      d_mode  = mode_ff;
      d_skip  = skip_ff;
      d_esc   = esc_ff;
      d_emits = 2'd0;
      if (skip_ff != 2'd0) begin
         d_skip = skip_ff - 2'd1;
      end else if (esc_ff) begin
         d_esc   = 1'b0;
         d_emits = 2'd1;
      end else begin
         unique case (mode_ff) inside
            MODE_LINE: begin
               if (f.c_nl) begin
                  d_mode  = MODE_NORMAL;
                  d_emits = 2'd1;
               end
            end
            MODE_BLOCK: begin
               if (f.c_star && f.n1_slash) begin
                  d_mode = MODE_NORMAL;
                  d_skip = 2'd1;
               end else if (f.c_nl) begin
                  d_emits = 2'd1;
               end
            end
            MODE_TEXT: begin
               d_emits = 2'd1;
               if (f.c_dquote && f.n1_dquote && f.n2_dquote) begin
                  d_mode  = MODE_NORMAL;
                  d_emits = 2'd3;
                  d_skip  = 2'd2;
               end
            end
            MODE_STRING, MODE_CHAR: begin
               d_emits = 2'd1;
               if (f.c_bslash) begin
                  d_esc = 1'b1;
               end else if ((mode_ff == MODE_STRING) ? f.c_dquote : f.c_squote) begin
                  d_mode = MODE_NORMAL;
               end
            end
            default: begin
               if (f.c_slash && f.n1_slash) begin
                  d_mode = MODE_LINE;
                  d_skip = 2'd1;
               end else if (f.c_slash && f.n1_star) begin
                  d_mode = MODE_BLOCK;
                  d_skip = 2'd1;
               end else if (f.c_dquote && f.n1_dquote && f.n2_dquote) begin
                  d_mode = MODE_TEXT;
                  d_skip = 2'd2;
               end else begin
                  if (f.c_dquote)      d_mode = MODE_STRING;
                  else if (f.c_squote) d_mode = MODE_CHAR;
                  d_emits = 2'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      skip_in       = skip_ff;
      esc_in        = esc_ff;
      rem_in        = rem_ff;
      cur_unit_in   = cur_unit_ff;
      cur_final_in  = cur_final_ff;
      end_pend_in   = end_pend_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      job_pop       = 1'b0;
      emit          = 1'b0;
      emit_unit     = cur_unit_ff;
      emit_final    = cur_final_ff;
      oq_push       = 1'b0;
      oq_word       = '0;
      if (!oq_full) begin
         if (rem_ff != 2'd0) begin
            emit   = 1'b1;
            rem_in = rem_ff - 2'd1;
         end else if (end_pend_ff) begin
            // Close the text: tag the held unit, or send a bare end marker.
            oq_push           = 1'b1;
            oq_word.out_unit  = held_valid_ff ? held_ff : '0;
            oq_word.out_valid = held_valid_ff;
            oq_word.out_last  = 1'b1;
            held_valid_in     = 1'b0;
            end_pend_in       = 1'b0;
            cur_final_in      = 1'b0;
            mode_in           = MODE_NORMAL;
            skip_in           = 2'd0;
            esc_in            = 1'b0;
         end else if (!job_empty) begin
            job_pop      = 1'b1;
            mode_in      = d_mode;
            skip_in      = d_skip;
            esc_in       = d_esc;
            cur_unit_in  = job_word.unit;
            cur_final_in = job_word.final_step;
            end_pend_in  = job_word.end_text;
            emit_unit    = job_word.unit;
            emit_final   = job_word.final_step;
            if (d_emits != 2'd0) begin
               emit   = 1'b1;
               rem_in = d_emits - 2'd1;
            end
         end
      end
      if (emit) begin
         // In the final step hold one unit back so the last one can be tagged.
         if (emit_final) begin
            held_in       = emit_unit;
            held_valid_in = 1'b1;
            if (held_valid_ff) begin
               oq_push           = 1'b1;
               oq_word.out_unit  = held_ff;
               oq_word.out_valid = 1'b1;
            end
         end else begin
            oq_push           = 1'b1;
            oq_word.out_unit  = emit_unit;
            oq_word.out_valid = 1'b1;
         end
      end
   end

   assign oq_full   = (oq_cnt_ff == (PTR_BITS+1)'(RSP_DEPTH));
   assign rsp_empty = (oq_cnt_ff == '0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      cur_unit_ff <= cur_unit_in;
      held_ff     <= held_in;
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_word;
      end
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         skip_ff       <= 2'd0;
         esc_ff        <= 1'b0;
         rem_ff        <= 2'd0;
         cur_final_ff  <= 1'b0;
         end_pend_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         oq_wr_ff      <= '0;
         oq_rd_ff      <= '0;
         oq_cnt_ff     <= '0;
      end else begin
         mode_ff       <= mode_in;
         skip_ff       <= skip_in;
         esc_ff        <= esc_in;
         rem_ff        <= rem_in;
         cur_final_ff  <= cur_final_in;
         end_pend_ff   <= end_pend_in;
         held_valid_ff <= held_valid_in;
         if (oq_push) oq_wr_ff <= oq_wr_ff + 1'b1;
         if (oq_pop)  oq_rd_ff <= oq_rd_ff + 1'b1;
         oq_cnt_ff <= oq_cnt_ff + (PTR_BITS+1)'(oq_push) - (PTR_BITS+1)'(oq_pop);
      end
   end

   // A bare end marker always closes a text.
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (oq_push && !oq_word.out_valid) |-> oq_word.out_last)
      else $error("end marker pushed without last tag");

   // A unit is held back only while a final step is in progress.
   a_held_in_final: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> cur_final_ff)
      else $error("unit held outside the final step");

   // Repeat emits come only from a text-block close, which leaves a skip of two.
   a_rem_after_close: assert property (@(posedge clock) disable iff (reset)
      (rem_ff == 2'd2) |-> (skip_ff == 2'd2 && mode_ff == MODE_NORMAL))
      else $error("repeat emits without a text-block close");

   // No new job is taken while the end of a text is still pending.
   a_no_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      end_pend_ff |-> !job_pop)
      else $error("job taken while end of text pending");

endmodule

/* rtl/core/java_comment_stripper.sv */
// Channel   | Ports                          | Word
// ----------+--------------------------------+---------------------------------
// request   | req_push, req_full, req_data   | req_type: code_unit, last_unit
// response  | rsp_pop, rsp_empty, rsp_data   | rsp_type: out_unit, out_valid, out_last
//
// One request word is taken per cycle while req_full is low; a unit is decided
// two words later, when its lookahead window is complete.
// A word with last_unit set makes the front flush the window (one decide job
// per buffered unit); the front takes no word then.
// A text-block close emits three words; every other decide emits at most one,
// so the back end takes one job/cycle while no emits or end marker are pending
// and the result queue has room. Reset is synchronous and active high.
// Each side stalls on its own: the job queue and result queue (4 words each)
// absorb stalls on rsp_pop without blocking req_push until they fill.
//
// Depends on jcs_pkg, jcs_front, jcs_job_fifo and jcs_back.
module java_comment_stripper
   import jcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    job_push;
   job_type job_in_word;
   logic    job_full;
   logic    job_pop;
   job_type job_out_word;
   logic    job_empty;

   // Front: hold the two-unit window, classify delimiters, flush at end of text.
   jcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_push (job_push),
      .job_word (job_in_word),
      .job_full (job_full)
   );

   // Queue: decouple window handling from the emit sequencer.
   jcs_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (job_in_word),
      .full      (job_full),
      .pop       (job_pop),
      .pop_word  (job_out_word),
      .empty     (job_empty)
   );

   // Back: advance the scan mode, drop comment text, emit kept units.
   jcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_word  (job_out_word),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/tb_java_comment_stripper.sv */
// Self-checking testbench for java_comment_stripper: queue-style push/full and
// empty/pop handshakes, a class that predicts every result word and checks it.
// Depends on jcs_pkg and the java_comment_stripper RTL.
module tb_java_comment_stripper
   import jcs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [UNIT_BITS-1:0] unit_type;

   // Predicts the stripped stream and holds the words still owed by the block.
   class strip_scoreboard;
      rsp_type owed[$];
      int      mismatches;
      logic [2:0] mode;
      unit_type quote_char;
      unit_type window[2];
      int      window_fill;
      int      skip_left;
      bit      copy_next;
      int      step_words;

      function new();
         mismatches = 0;
         clear_text();
      endfunction

      function void clear_text();
         mode        = MODE_NORMAL;
         quote_char  = '0;
         window[0]   = '0;
         window[1]   = '0;
         window_fill = 0;
         skip_left   = 0;
         copy_next   = 1'b0;
      endfunction

      // Keep one unit; a single input word yields at most four result words.
      function void keep(unit_type u);
         rsp_type r;
         if (step_words >= 4) return;
         r.out_unit  = u;
         r.out_valid = 1'b1;
         r.out_last  = 1'b0;
         owed.insert(owed.size(), r);
         step_words++;
      endfunction

      // Decide unit c with its two lookahead units (zero where missing).
      function void decide(unit_type c, unit_type n1, unit_type n2);
         if (skip_left != 0) begin
            skip_left--;
            return;
         end
         if (copy_next) begin
            copy_next = 1'b0;
            keep(c);
            return;
         end
         case (mode) inside
            MODE_LINE: begin
               if (c == CH_NL) begin
                  mode = MODE_NORMAL;
                  keep(c);
               end
               return;
            end
            MODE_BLOCK: begin
               if (c == CH_STAR && n1 == CH_SLASH) begin
                  mode      = MODE_NORMAL;
                  skip_left = 1;
               end else if (c == CH_NL) begin
                  keep(c);
               end
               return;
            end
            MODE_TEXT: begin
               keep(c);
               if (c == CH_DQUOTE && n1 == CH_DQUOTE && n2 == CH_DQUOTE) begin
                  mode = MODE_NORMAL;
                  keep(CH_DQUOTE);
                  keep(CH_DQUOTE);
                  skip_left = 2;
               end
               return;
            end
            MODE_STRING, MODE_CHAR: begin
               keep(c);
               if (c == CH_BSLASH) copy_next = 1'b1;
               else if (c == quote_char) mode = MODE_NORMAL;
               return;
            end
            default: ;
         endcase
         if (c == CH_SLASH && n1 == CH_SLASH) begin
            mode      = MODE_LINE;
            skip_left = 1;
         end else if (c == CH_SLASH && n1 == CH_STAR) begin
            mode      = MODE_BLOCK;
            skip_left = 1;
         end else if (c == CH_DQUOTE && n1 == CH_DQUOTE && n2 == CH_DQUOTE) begin
            mode      = MODE_TEXT;
            skip_left = 2;
         end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            mode       = (c == CH_DQUOTE) ? MODE_STRING : MODE_CHAR;
            quote_char = c;
            keep(c);
         end else begin
            keep(c);
         end
      endfunction

      // Note one accepted request word and queue the words it causes.
      function void note_word(req_type w);
         unit_type span[3];
         int      n;
         unit_type n1;
         unit_type n2;
         rsp_type tail;
         n = 0;
         step_words = 0;
         for (int k = 0; k < window_fill; k++) begin
            span[n] = window[k];
            n++;
         end
         span[n] = w.code_unit;
         n++;
         if (!w.last_unit) begin
            if (n == 3) begin
               decide(span[0], span[1], span[2]);
               window[0]   = span[1];
               window[1]   = span[2];
               window_fill = 2;
            end else begin
               for (int k = 0; k < n; k++) window[k] = span[k];
               window_fill = n;
            end
            return;
         end
         // Flush the window; lookahead past the end reads as zero.
         for (int k = 0; k < n; k++) begin
            n1 = (k + 1 < n) ? span[k + 1] : '0;
            n2 = (k + 2 < n) ? span[k + 2] : '0;
            decide(span[k], n1, n2);
         end
         if (step_words == 0) begin
            tail.out_unit  = '0;
            tail.out_valid = 1'b0;
            tail.out_last  = 1'b1;
            owed.insert(owed.size(), tail);
         end else begin
            tail = owed[owed.size() - 1];
            tail.out_last = 1'b1;
            owed[owed.size() - 1] = tail;
         end
         clear_text();
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: unit %h valid %b last %b",
                        got.out_unit, got.out_valid, got.out_last);
            return;
         end
         want = owed.pop_front();
         if (got.out_unit !== want.out_unit || got.out_valid !== want.out_valid ||
             got.out_last !== want.out_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected unit %h valid %b last %b, got unit %h valid %b last %b",
                        want.out_unit, want.out_valid, want.out_last,
                        got.out_unit, got.out_valid, got.out_last);
         end
      endfunction
   endclass

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   strip_scoreboard sb = new();
   req_type script[$];
   int      sent = 0;
   int      rx_count = 0;
   logic    hold_rsp = 1'b0;

   java_comment_stripper dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Append one word to the stimulus script.
   function void put(unit_type u, bit last);
      req_type w;
      w.code_unit = u;
      w.last_unit = last;
      script.insert(script.size(), w);
   endfunction

   function unit_type letter();
      return unit_type'(8'h61 + $urandom_range(0, 25));
   endfunction

   function unit_type any_unit();
      return unit_type'($urandom_range(0, 65535));
   endfunction

   // Body content: heavy on delimiters so bodies hit the mode transitions.
   function unit_type body_unit();
      case ($urandom_range(0, 7))
         0: return letter();
         1: return CH_NL;
         2: return CH_STAR;
         3: return CH_SLASH;
         4: return CH_DQUOTE;
         5: return CH_BSLASH;
         6: return any_unit();
         default: return CH_SQUOTE;
      endcase
   endfunction

   function unit_type plain_unit();
      return ($urandom_range(0, 1) != 0) ? letter() : any_unit();
   endfunction

   // Append one lexical piece of Java text; most are well formed.
   function void add_piece();
      int len;
      len = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
         0, 1: begin
            repeat (len + 1) put(plain_unit(), 1'b0);
         end
         2: begin
            put(CH_SLASH, 1'b0);
            put(CH_SLASH, 1'b0);
            repeat (len) put(body_unit(), 1'b0);
            put(CH_NL, 1'b0);
         end
         3: begin
            put(CH_SLASH, 1'b0);
            put(CH_STAR, 1'b0);
            repeat (len) put(body_unit(), 1'b0);
            put(CH_STAR, 1'b0);
            put(CH_SLASH, 1'b0);
         end
         4: begin
            put(CH_DQUOTE, 1'b0);
            repeat (len) begin
               if ($urandom_range(0, 3) == 0) begin
                  put(CH_BSLASH, 1'b0);
                  put(body_unit(), 1'b0);
               end else begin
                  put(plain_unit(), 1'b0);
               end
            end
            put(CH_DQUOTE, 1'b0);
         end
         5: begin
            put(CH_SQUOTE, 1'b0);
            if ($urandom_range(0, 2) == 0) put(CH_BSLASH, 1'b0);
            put(body_unit(), 1'b0);
            put(CH_SQUOTE, 1'b0);
         end
         6: begin
            repeat (3) put(CH_DQUOTE, 1'b0);
            repeat (len) put(body_unit(), 1'b0);
            repeat (3) put(CH_DQUOTE, 1'b0);
         end
         7: put(body_unit(), 1'b0);
         8: repeat ($urandom_range(1, 2)) put(any_unit(), 1'b0);
         default: put(CH_NL, 1'b0);
      endcase
   endfunction

   // Build one random text; mark its final word, sometimes cutting it short.
   function void add_text();
      int start;
      req_type w;
      start = script.size();
      repeat ($urandom_range(1, 4)) add_piece();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2))
            if (script.size() > start + 1) script.delete(script.size() - 1);
      end
      w = script[script.size() - 1];
      w.last_unit = 1'b1;
      script[script.size() - 1] = w;
   endfunction

   // Offer one word, idling first at random; return once it is taken.
   task automatic send_word(req_type w);
      bit steady;
      steady = (sent >= 150 && sent < 200) || hold_rsp;
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      sb.note_word(w);
      sent++;
   endtask

   // Pop side: check every word taken, then pick next cycle's pop, mostly at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            sb.check_word(rsp_data);
            rx_count++;
         end
         rsp_pop <= !hold_rsp &&
                    ((rx_count >= 60 && rx_count < 120) || $urandom_range(0, 99) >= 16);
      end
   end

   // Hold off popping for a long stretch once traffic is under way, so the
   // block fills and has to raise full.
   initial begin
      wait (sent >= 60);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (64) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog: end the run if nothing moves on either side for too long.
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stuck = 0;
         else stuck++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int directed;
      // Directed text: extremes of the unit, line comment hiding a zero unit,
      // block comment keeping its newline, string with an escaped quote,
      // char literal, and an empty text block whose close passes through.
      put(16'hFFFF, 1'b0);
      put(CH_SLASH, 1'b0);
      put(CH_SLASH, 1'b0);
      put(16'h0000, 1'b0);
      put(CH_NL, 1'b0);
      put(CH_SLASH, 1'b0);
      put(CH_STAR, 1'b0);
      put(CH_NL, 1'b0);
      put(CH_STAR, 1'b0);
      put(CH_SLASH, 1'b0);
      put(CH_DQUOTE, 1'b0);
      put(CH_BSLASH, 1'b0);
      put(CH_DQUOTE, 1'b0);
      put(CH_DQUOTE, 1'b0);
      put(CH_SQUOTE, 1'b0);
      put(16'h0000, 1'b0);
      put(CH_SQUOTE, 1'b0);
      repeat (5) put(CH_DQUOTE, 1'b0);
      put(CH_DQUOTE, 1'b1);
      // A text that keeps nothing: only the end marker comes out.
      put(CH_SLASH, 1'b0);
      put(CH_SLASH, 1'b1);
      // Backslash ends a literal: kept, the pending escape is dropped.
      put(CH_DQUOTE, 1'b0);
      put(CH_BSLASH, 1'b1);
      // Unterminated block comment, then a one-word text right after it.
      put(CH_SLASH, 1'b0);
      put(CH_STAR, 1'b1);
      put(16'h0000, 1'b1);
      directed = script.size();
      while (script.size() < directed + RANDOM_WORDS) add_text();

      // Hold reset, then stream the script.
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (script[i]) send_word(script[i]);
      req_push <= 1'b0;

      // Drain the block, then wait for any stray word.
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
